[hw/rtl/cttbl_pkg.sv]
// shared types and constants for the connection timer table
// used by the top level, the compare/subtract unit and the checks; depends on nothing
`default_nettype none

package cttbl_pkg;

	localparam int SLOTS     = 16;
	localparam int TIME_BITS = 24;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SLOT_W    = 4;
	localparam int ACT_W     = 3;
	localparam int REG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// request actions
	localparam logic [ACT_W-1:0] ACT_ARM_TW    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ARM_RT    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RELOAD_RT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DISARM_RT = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TW_TICK   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_RT_TICK   = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TW_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TW_STEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RT_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RT_STEP    = 2'd3;

	localparam logic [REG_W-1:0] RST_TW_TIMEOUT = 24'd2000000;
	localparam logic [REG_W-1:0] RST_TW_STEP    = 24'd100000;
	localparam logic [REG_W-1:0] RST_RT_TIMEOUT = 24'd200000;
	localparam logic [REG_W-1:0] RST_RT_STEP    = 24'd10000;

	localparam logic KIND_CLOSE   = 1'b0;
	localparam logic KIND_RETRANS = 1'b1;

	typedef struct packed {
		logic                 expire;
		logic [TIME_BITS-1:0] diff;
	} alu_res_t;

endpackage

`default_nettype wire

[hw/rtl/connection_timer_table.sv]
// connection timer table top level: sequencer, armed flags, config registers
// depends on cttbl_pkg, cttbl_ram, cttbl_alu
//
// Requests arrive on the s_ group: an action and a slot. Arm, reload and
// disarm requests finish in the cycle they are accepted. A time-wait or
// retransmit tick walks the slots one per cycle through the shared
// compare/subtract unit while the receiver keeps up, then passes through
// the flush state before s_tready returns high; the timer memories are
// read one slot ahead of the evaluation so the scan does not wait on the
// memory read for each slot. Each expiry comes out on the m_ group
// (slot in tdata, kind in tuser), the final one of a tick with tlast. One
// report is held back inside the block until the next is found or the scan
// ends, which is how tlast is known. s_tready is high only while no tick is
// being scanned. When the receiver stalls, the scan holds on the slot that
// has a new expiry until the output register frees up.
// Reset clears all armed and overdue flags, the output and the sequencer,
// and loads the register defaults; remaining-time memories are not cleared.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module connection_timer_table (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,  // action[2:0], slot[6:3], zero[7]
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [7:0]                        m_tdata,  // expired_slot[3:0], zero[7:4]
	output logic                                   m_tuser,  // event_kind[0]
	output logic                                   m_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [cttbl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cttbl_pkg::REG_W-1:0]       cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

	localparam int IW = cttbl_pkg::IDX_W;
	localparam int TW = cttbl_pkg::TIME_BITS;

	state_t                          state_q;
	logic [IW-1:0]                   idx_q;
	logic                            kind_q;
	logic [cttbl_pkg::SLOTS-1:0]     tw_armed_q, rt_armed_q, rt_over_q;
	logic                            pend_v_q;
	logic [IW-1:0]                   pend_idx_q;
	logic                            out_v_q, out_kind_q, out_last_q;
	logic [cttbl_pkg::SLOT_W-1:0]    out_slot_q;
	logic [cttbl_pkg::REG_W-1:0]     tw_timeout_q, tw_step_q, rt_timeout_q, rt_step_q;

	logic [cttbl_pkg::ACT_W-1:0]     action;
	logic [cttbl_pkg::SLOT_W-1:0]    slot;
	logic [IW-1:0]                   sidx;
	logic                            accept, slot_ok, out_free, out_load;
	logic                            scan, armed, over, hit, stall, go, last_idx;
	logic                            tw_we, rt_we;
	logic [IW-1:0]                   waddr, raddr;
	logic [TW-1:0]                   tw_wdata, rt_wdata, tw_rdata, rt_rdata;
	logic [TW-1:0]                   alu_left, alu_step, scan_wdata;
	cttbl_pkg::alu_res_t             alu_res;

	assign action   = s_tdata[2:0];
	assign slot     = s_tdata[6:3];
	assign sidx     = IW'(slot);
	assign slot_ok  = 32'(slot) < cttbl_pkg::SLOTS;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;

	assign scan     = (state_q == ST_SCAN);
	assign armed    = kind_q ? rt_armed_q[idx_q] : tw_armed_q[idx_q];
	assign over     = kind_q && rt_over_q[idx_q];
	assign alu_left = kind_q ? rt_rdata : tw_rdata;
	assign alu_step = kind_q ? TW'(rt_step_q) : TW'(tw_step_q);
	assign hit      = scan && armed && (over || alu_res.expire);
	// a second expiry needs the output register for the held-back report
	assign stall    = hit && pend_v_q && !out_free;
	assign go       = scan && !stall;
	assign last_idx = (idx_q == IW'(cttbl_pkg::SLOTS - 1));
	// output register takes the held-back report this cycle
	assign out_load = (go && hit && pend_v_q) ||
	                  ((state_q == ST_FLUSH) && pend_v_q && out_free);

	cttbl_alu u_alu (
		.left (alu_left),
		.step (alu_step),
		.res  (alu_res)
	);

	assign scan_wdata = alu_res.expire ? '0 : alu_res.diff;

	always_comb begin
		tw_we    = 1'b0;
		rt_we    = 1'b0;
		waddr    = sidx;
		tw_wdata = TW'(tw_timeout_q);
		rt_wdata = TW'(rt_timeout_q);
		if (accept && slot_ok) begin
			tw_we = (action == cttbl_pkg::ACT_ARM_TW);
			rt_we = (action == cttbl_pkg::ACT_RELOAD_RT) ||
			        ((action == cttbl_pkg::ACT_ARM_RT) && !rt_armed_q[sidx]);
		end else if (go && armed && !over) begin
			waddr    = idx_q;
			tw_wdata = scan_wdata;
			rt_wdata = scan_wdata;
			tw_we    = !kind_q;
			rt_we    = kind_q;
		end
	end

	// read one slot ahead while the scan advances
	always_comb begin
		if (go) begin
			raddr = idx_q + 1'b1;
		end else if (scan) begin
			raddr = idx_q;
		end else begin
			raddr = '0;
		end
	end

	cttbl_ram #(.WIDTH(TW), .DEPTH(cttbl_pkg::SLOTS)) u_tw_ram (
		.clk   (clk),
		.we    (tw_we),
		.waddr (waddr),
		.wdata (tw_wdata),
		.raddr (raddr),
		.rdata (tw_rdata)
	);

	cttbl_ram #(.WIDTH(TW), .DEPTH(cttbl_pkg::SLOTS)) u_rt_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (waddr),
		.wdata (rt_wdata),
		.raddr (raddr),
		.rdata (rt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_timeout_q <= cttbl_pkg::RST_TW_TIMEOUT;
			tw_step_q    <= cttbl_pkg::RST_TW_STEP;
			rt_timeout_q <= cttbl_pkg::RST_RT_TIMEOUT;
			rt_step_q    <= cttbl_pkg::RST_RT_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				cttbl_pkg::CFG_TW_TIMEOUT: tw_timeout_q <= cfg_data;
				cttbl_pkg::CFG_TW_STEP:    tw_step_q    <= cfg_data;
				cttbl_pkg::CFG_RT_TIMEOUT: rt_timeout_q <= cfg_data;
				cttbl_pkg::CFG_RT_STEP:    rt_step_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			kind_q     <= cttbl_pkg::KIND_CLOSE;
			tw_armed_q <= '0;
			rt_armed_q <= '0;
			rt_over_q  <= '0;
			pend_v_q   <= 1'b0;
			pend_idx_q <= '0;
			out_v_q    <= 1'b0;
			out_kind_q <= 1'b0;
			out_last_q <= 1'b0;
			out_slot_q <= '0;
		end else begin
			if (out_v_q && m_tready && !out_load) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							cttbl_pkg::ACT_ARM_TW: begin
								if (slot_ok) tw_armed_q[sidx] <= 1'b1;
							end
							cttbl_pkg::ACT_ARM_RT, cttbl_pkg::ACT_RELOAD_RT: begin
								if (slot_ok && (rt_we)) begin
									rt_armed_q[sidx] <= 1'b1;
									rt_over_q[sidx]  <= 1'b0;
								end
							end
							cttbl_pkg::ACT_DISARM_RT: begin
								if (slot_ok) begin
									rt_armed_q[sidx] <= 1'b0;
									rt_over_q[sidx]  <= 1'b0;
								end
							end
							cttbl_pkg::ACT_TW_TICK, cttbl_pkg::ACT_RT_TICK: begin
								state_q <= ST_SCAN;
								idx_q   <= '0;
								kind_q  <= (action == cttbl_pkg::ACT_RT_TICK);
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (go) begin
						if (hit) begin
							if (pend_v_q) begin
								out_v_q    <= 1'b1;
								out_slot_q <= cttbl_pkg::SLOT_W'(pend_idx_q);
								out_kind_q <= kind_q;
								out_last_q <= 1'b0;
							end
							pend_v_q   <= 1'b1;
							pend_idx_q <= idx_q;
							if (!over) begin
								if (kind_q) rt_over_q[idx_q] <= 1'b1;
								else        tw_armed_q[idx_q] <= 1'b0;
							end
						end
						idx_q <= idx_q + 1'b1;
						if (last_idx) state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_v_q    <= 1'b1;
						out_slot_q <= cttbl_pkg::SLOT_W'(pend_idx_q);
						out_kind_q <= kind_q;
						out_last_q <= 1'b1;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0, out_slot_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/cttbl_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module cttbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/cttbl_alu.sv]
// shared compare and subtract unit for the timer scan
// depends on cttbl_pkg
`default_nettype none

module cttbl_alu (
	input  wire logic [cttbl_pkg::TIME_BITS-1:0] left,
	input  wire logic [cttbl_pkg::TIME_BITS-1:0] step,
	output cttbl_pkg::alu_res_t                  res
);

	logic [cttbl_pkg::TIME_BITS:0] sub;

	// borrow out of the subtraction means left < step
	assign sub        = {1'b0, left} - {1'b0, step};
	assign res.expire = sub[cttbl_pkg::TIME_BITS];
	assign res.diff   = sub[cttbl_pkg::TIME_BITS-1:0];

endmodule

`default_nettype wire

[hw/rtl/cttbl_check.sv]
// port-level checks for the connection timer table, bound to the top level
// depends on cttbl_pkg and connection_timer_table
`default_nettype none

module cttbl_check (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [7:0]                      s_tdata,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [7:0]                      m_tdata,
	input wire logic                            m_tuser,
	input wire logic                            m_tlast,
	input wire logic                            cfg_we,
	input wire logic [cttbl_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [cttbl_pkg::REG_W-1:0]     cfg_data
);

	logic non_tick_req;

	assign non_tick_req = s_tvalid && s_tready &&
	                      (s_tdata[2:0] != cttbl_pkg::ACT_TW_TICK) &&
	                      (s_tdata[2:0] != cttbl_pkg::ACT_RT_TICK);

	// stalled report holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("stalled report changed");

	// a report without tlast means a tick scan is still running
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("request taken in the middle of a tick");

	// arm, reload and disarm requests give no report
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		non_tick_req && !m_tvalid |=> !m_tvalid)
		else $error("report after a non-tick request");

	// reports of one tick share their kind
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (m_tuser == $past(m_tuser)))
		else $error("report kind changed within a tick");

	logic unused_cfg;
	assign unused_cfg = cfg_we ^ (^cfg_index) ^ (^cfg_data);

endmodule

bind connection_timer_table cttbl_check u_cttbl_check (.*);

`default_nettype wire
